[hw/rtl/fp16_fp32_converter_top_assert.svh]
// Assertion macros used by the half/single converter top-level RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef FP16_FP32_CONVERTER_TOP_ASSERT_SVH
`define FP16_FP32_CONVERTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check, masked while reset is high.
`define FPC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define FPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPC_ASSERT(lbl, clk, rst, prop, msg)
`define FPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[hw/rtl/fpc_pkg.sv]
// Shared types and format constants for the half/single converter.
// No dependencies; imported by the conversion and top-level modules.
`default_nettype none

package fpc_pkg;

  typedef enum logic {
    OP_WIDEN  = 1'b0,
    OP_NARROW = 1'b1
  } op_t;

  localparam logic [7:0] SGL_EXP_ALL    = 8'hff;
  localparam logic [4:0] HLF_EXP_ALL    = 5'h1f;
  localparam logic [7:0] BIAS_DIFF      = 8'd112;  // 127 - 15
  localparam logic [7:0] HLF_EXP_OVF    = 8'd143;  // 2^16 and above
  localparam logic [7:0] HLF_EXP_MIN    = 8'd113;  // smallest normal half
  localparam logic [7:0] SUB_SHIFT_BASE = 8'd126;
  localparam logic [7:0] SUB_SHIFT_MAX  = 8'd25;

endpackage

`default_nettype wire

[hw/rtl/fp16_fp32_converter_top.sv]
// Top level of the half/single converter: input register, conversion
// logic, result register. Depends on fpc_pkg, fpc_widen, fpc_narrow and
// the assertion macro header.
//
//   channel   dir   payload                         handshake
//   s_*       in    tdata: operand; tuser: op        s_tvalid / s_tready
//   m_*       out   tdata: converted                 m_tvalid / m_tready
//
// An accepted request passes from the input register through the single
// conversion pass to the result register; one request per cycle is taken
// while s_tready is high. Reset (rst, synchronous) empties both
// registers. A stalled result holds; the input register still fills while
// the result register is occupied, and s_tready drops once both are full.
`default_nettype none
`include "fp16_fp32_converter_top_assert.svh"

module fp16_fp32_converter_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] operand
  input  wire logic        s_tuser,   // [0] op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata    // [31:0] converted
);
  import fpc_pkg::*;

  logic        in_valid;
  op_t         in_op;
  logic [31:0] in_operand;
  logic        out_valid;
  op_t         out_op;
  logic [31:0] out_data;

  logic        out_free;
  logic        out_load;
  logic [31:0] widened;
  logic [15:0] narrowed;
  logic [31:0] out_data_next;

  fpc_widen u_widen (
    .operand (in_operand[15:0]),
    .result  (widened)
  );

  fpc_narrow u_narrow (
    .operand (in_operand),
    .result  (narrowed)
  );

  assign out_free = !out_valid || m_tready;
  assign out_load = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_comb begin
    unique case (in_op)
      OP_WIDEN:  out_data_next = widened;
      OP_NARROW: out_data_next = {16'b0, narrowed};
      default:   out_data_next = widened;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (out_free) out_valid <= in_valid;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op      <= op_t'(s_tuser);
      in_operand <= s_tdata;
    end
    if (out_load) begin
      out_op   <= in_op;
      out_data <= out_data_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  `FPC_ASSERT(a_accept_fills, clk, rst, s_tvalid && s_tready |=> in_valid, "accepted request lost")
  `FPC_ASSERT(a_advance, clk, rst, in_valid && out_free |=> out_valid, "request did not advance")
  `FPC_ASSERT(a_narrow_upper, clk, rst, m_tvalid && out_op == OP_NARROW |-> m_tdata[31:16] == 16'h0, "narrowed result upper half not zero")
  `FPC_ASSERT_ALWAYS(a_empty_ready, clk, !in_valid |-> s_tready, "ready low with empty input register")

endmodule

`default_nettype wire

[hw/rtl/fpc_widen.sv]
// Half to single widening, purely combinational and exact.
// Depends on fpc_pkg for format constants.
`default_nettype none

module fpc_widen (
  input  wire logic [15:0] operand,
  output logic      [31:0] result
);
  import fpc_pkg::*;

  logic       sign;
  logic [4:0] ex;
  logic [9:0] man;
  logic [3:0] lz;
  logic [9:0] man_sh;
  logic [7:0] sub_exp;

  assign sign = operand[15];
  assign ex   = operand[14:10];
  assign man  = operand[9:0];

  // leading zero count of a subnormal mantissa; highest set bit wins
  always_comb begin
    lz = '0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) lz = 4'(9 - i);
    end
  end

  assign man_sh  = man << lz;
  assign sub_exp = BIAS_DIFF - {4'b0, lz};

  always_comb begin
    priority if (ex == HLF_EXP_ALL) begin
      if (man != '0) result = {sign, SGL_EXP_ALL, 1'b1, man[8:0], 13'b0};
      else           result = {sign, SGL_EXP_ALL, 23'b0};
    end else if (ex != '0) begin
      result = {sign, {3'b0, ex} + BIAS_DIFF, man, 13'b0};
    end else if (man == '0) begin
      result = {sign, 31'b0};
    end else begin
      // drop the leading one after normalizing
      result = {sign, sub_exp, man_sh[8:0], 14'b0};
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fpc_narrow.sv]
// Single to half narrowing with round-to-nearest-even over normal and
// subnormal half ranges. Combinational; depends on fpc_pkg.
`default_nettype none

module fpc_narrow (
  input  wire logic [31:0] operand,
  output logic      [15:0] result
);
  import fpc_pkg::*;

  logic        sign;
  logic [7:0]  ex;
  logic [22:0] man;
  logic [7:0]  norm_exp;
  logic [14:0] norm_base;
  logic        norm_up;
  logic [14:0] norm_rnd;
  logic [7:0]  shift;
  logic [47:0] shifted;
  logic [10:0] sub_base;
  logic        sub_up;
  logic [10:0] sub_rnd;

  assign sign = operand[31];
  assign ex   = operand[30:23];
  assign man  = operand[22:0];

  assign norm_exp  = ex - BIAS_DIFF;
  assign norm_base = {norm_exp[4:0], man[22:13]};
  assign norm_up   = man[12] && ((|man[11:0]) || norm_base[0]);
  // carry out of the mantissa may land exactly on infinity
  assign norm_rnd  = norm_base + {14'b0, norm_up};

  // subnormal half: shift is 14..24 whenever this path is taken
  assign shift    = SUB_SHIFT_BASE - ex;
  assign shifted  = {1'b1, man, 24'b0} >> shift[4:0];
  assign sub_base = shifted[34:24];
  assign sub_up   = shifted[23] && ((|shifted[22:0]) || sub_base[0]);
  assign sub_rnd  = sub_base + {10'b0, sub_up};

  always_comb begin
    priority if (ex == SGL_EXP_ALL) begin
      if (man != '0) result = {sign, HLF_EXP_ALL, 1'b1, man[21:13]};
      else           result = {sign, HLF_EXP_ALL, 10'b0};
    end else if (ex >= HLF_EXP_OVF) begin
      result = {sign, HLF_EXP_ALL, 10'b0};
    end else if (ex >= HLF_EXP_MIN) begin
      result = {sign, norm_rnd};
    end else if (ex == '0 || shift >= SUB_SHIFT_MAX) begin
      result = {sign, 15'b0};
    end else begin
      result = {sign, 4'b0, sub_rnd};
    end
  end

endmodule

`default_nettype wire

[sim/tb_fp16_fp32_converter_top.sv]
// Self-checking testbench for fp16_fp32_converter_top: half/single conversions both ways,
// with a local predictor and random stalls on both streams.
// Depends on fpc_pkg and the converter RTL only.
`timescale 1ns / 100ps

module tb_fp16_fp32_converter_top;
  import fpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = 32'd0;   // [31:0] operand
  logic        s_tuser  = OP_WIDEN; // [0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;            // [31:0] converted

  logic [31:0] expected_converted_q[$];
  int          mismatches   = 0;
  int          tx_idle_pct  = 0;
  int          rx_idle_pct  = 0;
  int          rx_hold_left = 0;
  int          quiet_cycles = 0;

  fp16_fp32_converter_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic        sgn;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [32:0] shifted;
    int          p;
    sgn = h[15];
    ex  = h[14:10];
    man = h[9:0];
    if (ex == HLF_EXP_ALL) begin
      // NaN comes out quiet with the payload kept
      if (man != 10'd0) return {sgn, SGL_EXP_ALL, 1'b1, man[8:0], 13'd0};
      return {sgn, SGL_EXP_ALL, 23'd0};
    end
    if (ex != 5'd0) return {sgn, 8'({3'd0, ex}) + BIAS_DIFF, man, 13'd0};
    if (man == 10'd0) return {sgn, 31'd0};
    // subnormal: renormalize around the leading one
    p = 9;
    while (!man[p]) p--;
    shifted = 33'(man) << (23 - p);
    return {sgn, 8'(p + 103), shifted[22:0]};
  endfunction

  function automatic logic [15:0] single_to_half(input logic [31:0] f);
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [7:0]  hexp;
    logic [15:0] base;
    logic [23:0] sig;
    logic [23:0] rem;
    logic [23:0] halfway;
    int          sh;
    sgn = f[31];
    ex  = f[30:23];
    man = f[22:0];
    if (ex == SGL_EXP_ALL) begin
      if (man != 23'd0) return {sgn, HLF_EXP_ALL, 1'b1, man[21:13]};
      return {sgn, HLF_EXP_ALL, 10'd0};
    end
    if (ex >= HLF_EXP_OVF) return {sgn, HLF_EXP_ALL, 10'd0};
    if (ex >= HLF_EXP_MIN) begin
      hexp = ex - BIAS_DIFF;
      base = {1'b0, hexp[4:0], man[22:13]};
      // a carry out of the mantissa may land exactly on infinity
      if (man[12:0] > 13'h1000 || (man[12:0] == 13'h1000 && base[0])) base = base + 16'd1;
      return {sgn, base[14:0]};
    end
    if (ex == 8'd0) return {sgn, 15'd0};
    sh = int'(SUB_SHIFT_BASE) - int'(ex);
    if (sh >= int'(SUB_SHIFT_MAX)) return {sgn, 15'd0};
    sig     = {1'b1, man};
    base    = 16'(sig >> sh);
    rem     = sig & ((24'd1 << sh) - 24'd1);
    halfway = 24'd1 << (sh - 1);
    if (rem > halfway || (rem == halfway && base[0])) base = base + 16'd1;
    return {sgn, base[14:0]};
  endfunction

  function automatic logic [31:0] predict_conversion(input op_t op, input logic [31:0] operand);
    if (op == OP_WIDEN) return half_to_single(operand[15:0]);
    return {16'd0, single_to_half(operand)};
  endfunction

  // ------------------------------------------------------------- operand mix
  function automatic logic [31:0] rand_single();
    logic [31:0] v;
    logic [31:0] mask;
    logic [31:0] tie;
    int          ex;
    int          sh;
    v = $urandom();
    case ($urandom_range(9))
      0, 1, 2: ;
      3, 4, 5, 6: v[30:23] = 8'($urandom_range(146, 98));
      7: begin
        // land on or next to the rounding midpoint
        ex = $urandom_range(142, 103);
        sh = (ex >= 113) ? 13 : 126 - ex;
        mask = (32'd1 << sh) - 32'd1;
        tie  = (32'd1 << (sh - 1)) + 32'($urandom_range(2)) - 32'd1;
        v[30:23] = 8'(ex);
        v[22:0]  = 23'((v & ~mask) | (tie & mask));
      end
      8: begin
        v[30:23] = $urandom_range(1) ? SGL_EXP_ALL : 8'd0;
        if ($urandom_range(2) == 0) v[22:0] = 23'd0;
      end
      default: v[30:23] = 8'($urandom_range(102));
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_half();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(9))
      6, 7: v[14:10] = 5'd0;
      8:    v[14:10] = HLF_EXP_ALL;
      9:    v[9:0]   = 10'd0;
      default: ;
    endcase
    return v;
  endfunction

  // -------------------------------------------------------------- stream side
  // Leaves s_tvalid high after the handshake; the next request or a drain takes it down.
  task automatic send_request(input op_t op, input logic [31:0] operand);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= operand;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_converted_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // record each accepted request
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      expected_converted_q.push_back(predict_conversion(op_t'(s_tuser), s_tdata));
  end

  // compare each accepted result against the oldest prediction
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_converted_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected result converted=%08h", $realtime, m_tdata);
        mismatches++;
      end else begin
        want = expected_converted_q.pop_front();
        if (m_tdata !== want) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: converted mismatch: expected %08h actual %08h",
                     $realtime, want, m_tdata);
          mismatches++;
        end
      end
    end
  end

  // receiver: long hold-offs first, random stalls otherwise
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("fp16_fp32_converter_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------ tests
  task automatic test_directed();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_request(OP_WIDEN,  32'h0000_0000);  // +0
    send_request(OP_WIDEN,  32'h0000_8000);  // -0
    send_request(OP_WIDEN,  32'h0000_0001);  // smallest subnormal
    send_request(OP_WIDEN,  32'h0000_83ff);  // largest subnormal, negative
    send_request(OP_WIDEN,  32'h0000_0400);  // smallest normal
    send_request(OP_WIDEN,  32'h0000_7bff);  // largest normal
    send_request(OP_WIDEN,  32'h0000_7c00);  // +inf
    send_request(OP_WIDEN,  32'h0000_fc00);  // -inf
    send_request(OP_WIDEN,  32'h0000_7c01);  // signaling NaN goes quiet
    send_request(OP_WIDEN,  32'hffff_fe00);  // quiet NaN, upper bits set
    send_request(OP_WIDEN,  32'hdead_3c00);  // upper bits ignored
    send_request(OP_NARROW, 32'h3f80_0000);  // 1.0
    send_request(OP_NARROW, 32'h477f_e000);  // largest half
    send_request(OP_NARROW, 32'h477f_f000);  // tie rounds up into infinity
    send_request(OP_NARROW, 32'hc780_0000);  // overflow, negative
    send_request(OP_NARROW, 32'h7f80_0000);  // +inf
    send_request(OP_NARROW, 32'h7f80_0001);  // NaN with low payload only
    send_request(OP_NARROW, 32'hffff_ffff);  // NaN, all payload bits
    send_request(OP_NARROW, 32'h8000_0001);  // single subnormal
    send_request(OP_NARROW, 32'h3300_0000);  // half of smallest subnormal, ties to zero
    send_request(OP_NARROW, 32'h3300_0001);  // just above that midpoint
    send_request(OP_NARROW, 32'h3380_0000);  // smallest subnormal exactly
    send_request(OP_NARROW, 32'h387f_e000);  // subnormal carries into smallest normal
    send_request(OP_NARROW, 32'h3f80_1000);  // normal tie, even stays
    send_request(OP_NARROW, 32'h3f80_3000);  // normal tie, odd rounds up
    drain_results();
  endtask

  task automatic test_random_stream(input int count, input int tx_pct, input int rx_pct);
    op_t op;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) begin
      op = op_t'($urandom_range(1));
      send_request(op, (op == OP_WIDEN) ? rand_half() : rand_single());
    end
    drain_results();
  endtask

  // hold the receiver off so both registers fill and the input stalls
  task automatic test_backpressure();
    op_t op;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    rx_hold_left = 250;
    repeat (60) begin
      op = op_t'($urandom_range(1));
      send_request(op, (op == OP_WIDEN) ? rand_half() : rand_single());
    end
    drain_results();
  endtask

  // short bursts, each drained before the next
  task automatic test_burst_pause();
    op_t op;
    tx_idle_pct = 0;
    rx_idle_pct = 30;
    repeat (10) begin
      repeat (8) begin
        op = op_t'($urandom_range(1));
        send_request(op, (op == OP_WIDEN) ? rand_half() : rand_single());
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_stream(400, 7, 71);
    test_random_stream(400, 71, 7);
    test_random_stream(400, 0, 0);
    test_backpressure();
    test_burst_pause();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_converted_q.size() == 0) begin
      $display("fp16_fp32_converter_top regression: pass");
    end else begin
      $display("fp16_fp32_converter_top regression: fail");
    end
    $finish;
  end

endmodule
